FILE: design/bdqs_pkg.sv
`default_nettype none
package bdqs_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RES_OK,
    RES_EMPTY,
    RES_FULL,
    RES_POP,
    RES_FOUND,
    RES_NOT_FOUND
  } res_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      scan_start;
    logic      scan_step;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            hit;
    logic            scan_last;
    logic            out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/bounded_deque_with_search_unit.sv
// Bounded double-ended queue of signed values with linear search.
// Input channel: in_valid/in_stall with in_op (push front, push back, pop front,
// pop back, search) and in_value. Every accepted item yields exactly one result
// on out_valid/out_stall: out_status, out_removed_value, out_position.
// Items are handled one at a time; in_stall is low only while the controller
// is idle. Pushes, unused codes and operations on an empty store go from
// S_EXEC straight to S_DONE; a pop passes through S_POP_RD, and a search
// scans from the front until it hits or has compared every stored entry.
// The next item is accepted only once the result has moved to the output
// register; the scan reads one entry per cycle through the single read port
// of the entry memory.
// The result sits in an output register, so a new item is accepted and worked
// on while an earlier result waits under out_stall; a finished result then
// waits in a staging register until the output register frees up.
// Reset (rst_n low, synchronous) empties the store and drops out_valid; the
// entry memory itself is not cleared.
`default_nettype none
module bounded_deque_with_search_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire        [bdqs_pkg::OP_W-1:0]        in_op,
  input  wire signed [bdqs_pkg::VALUE_W-1:0]     in_value,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic       [bdqs_pkg::STATUS_W-1:0]    out_status,
  output logic signed [bdqs_pkg::VALUE_W-1:0]    out_removed_value,
  output logic       [bdqs_pkg::POS_W-1:0]       out_position
);

  bdqs_pkg::cmd_t cmd;
  bdqs_pkg::sts_t sts;

  bdqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdqs_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_value          (in_value),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_position      (out_position)
  );

endmodule
`default_nettype wire

FILE: design/bdqs_dp.sv
`default_nettype none
module bdqs_dp #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire bdqs_pkg::cmd_t                      cmd,
  output bdqs_pkg::sts_t                           sts,
  input  wire        [bdqs_pkg::OP_W-1:0]          in_op,
  input  wire signed [bdqs_pkg::VALUE_W-1:0]       in_value,
  input  wire                                      out_stall,
  output logic                                     out_valid,
  output logic       [bdqs_pkg::STATUS_W-1:0]      out_status,
  output logic signed [bdqs_pkg::VALUE_W-1:0]      out_removed_value,
  output logic       [bdqs_pkg::POS_W-1:0]         out_position
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = OCC_W + 1;
  localparam int unsigned PW    = (SUM_W > bdqs_pkg::POS_W) ? SUM_W : bdqs_pkg::POS_W;
  localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [OCC_W-1:0] cmp_off_r, cmp_off_nxt;
  logic [OCC_W-1:0] next_off_r, next_off_nxt;
  logic [bdqs_pkg::OP_W-1:0] op_r;
  logic [DATA_WIDTH-1:0] key_r;

  logic [bdqs_pkg::STATUS_W-1:0]     rs_status_r, rs_status_nxt;
  logic [bdqs_pkg::VALUE_W-1:0]      rs_removed_r, rs_removed_nxt;
  logic [bdqs_pkg::POS_W-1:0]        rs_pos_r, rs_pos_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [bdqs_pkg::STATUS_W-1:0]     out_status_r;
  logic [bdqs_pkg::VALUE_W-1:0]      out_removed_r;
  logic [bdqs_pkg::POS_W-1:0]        out_pos_r;

  logic [63:0]           in_ext;
  logic [63:0]           rd_ext;
  logic [OCC_W-1:0]      off;
  logic [SUM_W-1:0]      sum;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      front_dec;
  logic [IDX_W-1:0]      front_inc;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic                  rd_en;
  logic [PW-1:0]         pos_w;
  logic                  empty;
  logic                  full;
  logic                  is_front;

  assign in_ext   = 64'(in_value);
  assign rd_ext   = 64'($signed(rd_data_r));
  assign empty    = (occ_r == '0);
  assign full     = (occ_r == OCC_W'(CAPACITY));
  assign is_front = (op_r == bdqs_pkg::OP_PUSH_FRONT) || (op_r == bdqs_pkg::OP_POP_FRONT);

  // offset into the circular store, relative to the front
  always_comb begin
    off = '0;
    if (cmd.push && op_r == bdqs_pkg::OP_PUSH_BACK) begin
      off = occ_r;
    end else if (cmd.pop && op_r == bdqs_pkg::OP_POP_BACK) begin
      off = occ_r - OCC_W'(1);
    end else if (cmd.scan_step) begin
      off = next_off_r;
    end
  end

  // both operands are below CAPACITY, so one conditional subtract wraps
  always_comb begin
    sum = SUM_W'(front_r) + SUM_W'(off);
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    slot = sum[IDX_W-1:0];
  end

  assign front_dec = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_W'(CAPACITY - 1)) ? '0 : front_r + IDX_W'(1);

  assign wr_en   = cmd.push;
  assign wr_addr = is_front ? front_dec : slot;
  assign rd_en   = cmd.pop || cmd.scan_start || cmd.scan_step;
  assign rd_addr = (cmd.pop && is_front) ? front_r : slot;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    front_nxt    = front_r;
    occ_nxt      = occ_r;
    cmp_off_nxt  = cmp_off_r;
    next_off_nxt = next_off_r;
    if (cmd.push) begin
      occ_nxt = occ_r + OCC_W'(1);
      if (is_front) begin
        front_nxt = front_dec;
      end
    end
    if (cmd.pop) begin
      occ_nxt = occ_r - OCC_W'(1);
      if (is_front) begin
        front_nxt = front_inc;
      end
    end
    if (cmd.scan_start) begin
      cmp_off_nxt  = '0;
      next_off_nxt = OCC_W'(1);
    end
    if (cmd.scan_step) begin
      cmp_off_nxt  = next_off_r;
      next_off_nxt = next_off_r + OCC_W'(1);
    end
  end

  assign pos_w = PW'(cmp_off_r) + PW'(1);

  always_comb begin
    rs_status_nxt  = rs_status_r;
    rs_removed_nxt = rs_removed_r;
    rs_pos_nxt     = rs_pos_r;
    if (cmd.res_load) begin
      rs_removed_nxt = '0;
      rs_pos_nxt     = '0;
      unique case (cmd.res_kind)
        bdqs_pkg::RES_OK: begin
          rs_status_nxt = bdqs_pkg::ST_OK;
        end
        bdqs_pkg::RES_EMPTY: begin
          rs_status_nxt = bdqs_pkg::ST_EMPTY;
        end
        bdqs_pkg::RES_FULL: begin
          rs_status_nxt = bdqs_pkg::ST_FULL;
        end
        bdqs_pkg::RES_POP: begin
          rs_status_nxt  = bdqs_pkg::ST_OK;
          rs_removed_nxt = rd_ext[bdqs_pkg::VALUE_W-1:0];
        end
        bdqs_pkg::RES_FOUND: begin
          rs_status_nxt = bdqs_pkg::ST_OK;
          rs_pos_nxt    = pos_w[bdqs_pkg::POS_W-1:0];
        end
        bdqs_pkg::RES_NOT_FOUND: begin
          rs_status_nxt = bdqs_pkg::ST_NOT_FOUND;
        end
        default: begin
          rs_status_nxt = bdqs_pkg::ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_off_r    <= cmp_off_nxt;
    next_off_r   <= next_off_nxt;
    rs_status_r  <= rs_status_nxt;
    rs_removed_r <= rs_removed_nxt;
    rs_pos_r     <= rs_pos_nxt;
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= in_ext[DATA_WIDTH-1:0];
    end
    if (cmd.out_load) begin
      out_status_r  <= rs_status_r;
      out_removed_r <= rs_removed_r;
      out_pos_r     <= rs_pos_r;
    end
  end

  assign sts.op        = op_r;
  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.hit       = (rd_data_r == key_r);
  assign sts.scan_last = ((cmp_off_r + OCC_W'(1)) == occ_r);
  assign sts.out_busy  = out_valid_r && out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_position      = out_pos_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !full)
    else $error("push issued into a full store");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !empty)
    else $error("pop issued on an empty store");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (cmp_off_r < occ_r))
    else $error("search ran past the last entry");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy ##1 out_valid)
    else $error("result loaded over a waiting item");
`endif

endmodule
`default_nettype wire

FILE: design/bdqs_ctrl.sv
`default_nettype none
module bdqs_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire bdqs_pkg::sts_t  sts,
  output bdqs_pkg::cmd_t       cmd
);

  bdqs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdqs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_kind = bdqs_pkg::RES_OK;
    in_stall     = 1'b1;
    unique case (state_r)
      bdqs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bdqs_pkg::S_EXEC;
        end
      end
      bdqs_pkg::S_EXEC: begin
        unique case (sts.op) inside
          bdqs_pkg::OP_PUSH_FRONT, bdqs_pkg::OP_PUSH_BACK: begin
            cmd.res_load = 1'b1;
            if (sts.full) begin
              cmd.res_kind = bdqs_pkg::RES_FULL;
            end else begin
              cmd.push     = 1'b1;
              cmd.res_kind = bdqs_pkg::RES_OK;
            end
            state_nxt = bdqs_pkg::S_DONE;
          end
          bdqs_pkg::OP_POP_FRONT, bdqs_pkg::OP_POP_BACK: begin
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = bdqs_pkg::RES_EMPTY;
              state_nxt    = bdqs_pkg::S_DONE;
            end else begin
              cmd.pop   = 1'b1;
              state_nxt = bdqs_pkg::S_POP_RD;
            end
          end
          bdqs_pkg::OP_SEARCH: begin
            if (sts.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = bdqs_pkg::RES_EMPTY;
              state_nxt    = bdqs_pkg::S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = bdqs_pkg::S_SCAN;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = bdqs_pkg::RES_OK;
            state_nxt    = bdqs_pkg::S_DONE;
          end
        endcase
      end
      bdqs_pkg::S_POP_RD: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = bdqs_pkg::RES_POP;
        state_nxt    = bdqs_pkg::S_DONE;
      end
      bdqs_pkg::S_SCAN: begin
        // read data for one offset arrives while the next is being read
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bdqs_pkg::RES_FOUND;
          state_nxt    = bdqs_pkg::S_DONE;
        end else if (sts.scan_last) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = bdqs_pkg::RES_NOT_FOUND;
          state_nxt    = bdqs_pkg::S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      bdqs_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = bdqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bdqs_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_goes_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == bdqs_pkg::S_EXEC))
    else $error("accepted item did not start execution");

  a_pop_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (state_r == bdqs_pkg::S_POP_RD))
    else $error("pop read not followed");

  a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == bdqs_pkg::S_IDLE))
    else $error("result handed off outside completion");
`endif

endmodule
`default_nettype wire

FILE: sim/bounded_deque_with_search_unit_tb.sv
`default_nettype none
module bounded_deque_with_search_unit_tb;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 80;

  // op codes the block does not define
  localparam logic [bdqs_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [bdqs_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [bdqs_pkg::OP_W-1:0]    op;
    logic [bdqs_pkg::VALUE_W-1:0] value;
    bit                           drain;  // wait for all results before offering
    bit                           hold;   // start the long receiver hold-off
    bit                           calm;   // no idling on either side
  } deque_item_t;

  typedef struct {
    logic [bdqs_pkg::STATUS_W-1:0] status;
    logic [bdqs_pkg::VALUE_W-1:0]  removed;
    logic [bdqs_pkg::POS_W-1:0]    position;
  } deque_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bdqs_pkg::OP_W-1:0] in_op = '0;
  logic [bdqs_pkg::VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bdqs_pkg::STATUS_W-1:0] out_status;
  logic [bdqs_pkg::VALUE_W-1:0] out_removed_value;
  logic [bdqs_pkg::POS_W-1:0] out_position;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;

  deque_item_t pending_q[$];
  deque_result_t expected_q[$];
  logic [bdqs_pkg::VALUE_W-1:0] deque_model_q[$];
  int unsigned mismatches = 0;

  bounded_deque_with_search_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_position      (out_position)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one op to the deque model and returns the result it should give.
  function automatic deque_result_t predict_result(
      input logic [bdqs_pkg::OP_W-1:0] op,
      input logic [bdqs_pkg::VALUE_W-1:0] value);
    deque_result_t res;
    res.status = bdqs_pkg::ST_OK;
    res.removed = '0;
    res.position = '0;
    case (op) inside
      bdqs_pkg::OP_PUSH_FRONT, bdqs_pkg::OP_PUSH_BACK: begin
        if (deque_model_q.size() >= DEPTH) begin
          res.status = bdqs_pkg::ST_FULL;
        end else if (op == bdqs_pkg::OP_PUSH_FRONT) begin
          deque_model_q.push_front(value);
        end else begin
          deque_model_q.push_back(value);
        end
      end
      bdqs_pkg::OP_POP_FRONT, bdqs_pkg::OP_POP_BACK: begin
        if (deque_model_q.size() == 0) begin
          res.status = bdqs_pkg::ST_EMPTY;
        end else if (op == bdqs_pkg::OP_POP_FRONT) begin
          res.removed = deque_model_q.pop_front();
        end else begin
          res.removed = deque_model_q.pop_back();
        end
      end
      bdqs_pkg::OP_SEARCH: begin
        if (deque_model_q.size() == 0) begin
          res.status = bdqs_pkg::ST_EMPTY;
        end else begin
          res.status = bdqs_pkg::ST_NOT_FOUND;
          for (int i = 0; i < deque_model_q.size(); i++) begin
            if (deque_model_q[i] == value) begin
              res.status = bdqs_pkg::ST_OK;
              res.position = bdqs_pkg::POS_W'(i + 1);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_item(input logic [bdqs_pkg::OP_W-1:0] op,
                          input logic [bdqs_pkg::VALUE_W-1:0] value,
                          input bit drain, input bit hold, input bit calm_seg);
    deque_item_t it;
    it.op = op;
    it.value = value;
    it.drain = drain;
    it.hold = hold;
    it.calm = calm_seg;
    pending_q.push_back(it);
  endtask

  // A small pool so searches hit, plus extremes and, most often, full-range values.
  function automatic logic [bdqs_pkg::VALUE_W-1:0] pick_value();
    logic [bdqs_pkg::VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: v = bdqs_pkg::VALUE_W'($urandom_range(7)) - bdqs_pkg::VALUE_W'(4);
      1: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Sender: offers items at the falling edge, with a drawn gap after each one.
  always @(negedge clk) begin : send_items
    deque_item_t it;
    int unsigned gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && expected_q.size() != 0)) begin
        it = pending_q.pop_front();
        in_op <= it.op;
        in_value <= it.value;
        in_valid <= 1'b1;
        calm <= it.calm;
        if (it.hold) begin
          hold_go <= 1'b1;
        end
        gap_left = it.calm ? 0 : $urandom_range(6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls each offered result for a drawn number of cycles.
  always @(negedge clk) begin : take_results
    int unsigned stall_left;
    int unsigned hold_left;
    bit hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (out_took) begin
        stall_left = calm ? 0 : $urandom_range(6);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        if (out_valid) begin
          stall_left--;
        end
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d removed=%h pos=%0d",
                                    out_status, out_removed_value, out_position));
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          end
          if (out_removed_value !== want.removed) begin
            report_mismatch($sformatf("removed_value %h, want %h",
                                      out_removed_value, want.removed));
          end
          if (out_position !== want.position) begin
            report_mismatch($sformatf("position %0d, want %0d",
                                      out_position, want.position));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_result(in_op, in_value));
      end
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned count;
    int unsigned seg_len;
    int unsigned push_pct;
    int unsigned r;
    int unsigned mode;
    bit seg_calm;
    bit seg_drain;
    logic [bdqs_pkg::OP_W-1:0] op;

    // empty store, spare codes, extremes, hits and misses
    add_item(bdqs_pkg::OP_POP_FRONT, '0, 0, 0, 0);
    add_item(bdqs_pkg::OP_POP_BACK, '1, 0, 0, 0);
    add_item(bdqs_pkg::OP_SEARCH, '0, 0, 0, 0);
    for (int c = OP_SPARE_5; c <= OP_SPARE_7; c++) begin
      add_item(bdqs_pkg::OP_W'(c), $urandom(), 0, 0, 0);
    end
    add_item(bdqs_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 0, 0, 0);
    add_item(bdqs_pkg::OP_PUSH_FRONT, 32'h8000_0000, 0, 0, 0);
    add_item(bdqs_pkg::OP_PUSH_BACK, '1, 0, 0, 0);
    add_item(bdqs_pkg::OP_PUSH_FRONT, '0, 0, 0, 0);
    add_item(bdqs_pkg::OP_SEARCH, 32'h7fff_ffff, 0, 0, 0);
    add_item(bdqs_pkg::OP_SEARCH, 32'h0001_2345, 0, 0, 0);
    add_item(bdqs_pkg::OP_SEARCH, '1, 0, 0, 0);
    add_item(bdqs_pkg::OP_SEARCH, '0, 0, 0, 0);
    add_item(bdqs_pkg::OP_POP_FRONT, '0, 0, 0, 0);
    add_item(bdqs_pkg::OP_POP_BACK, '0, 0, 0, 0);
    add_item(bdqs_pkg::OP_POP_BACK, '0, 0, 0, 0);
    add_item(bdqs_pkg::OP_POP_FRONT, '0, 0, 0, 0);
    add_item(bdqs_pkg::OP_POP_BACK, '0, 0, 0, 0);

    // fill past capacity; the receiver holds off early on so the block backs up
    for (int i = 0; i < DEPTH + 6; i++) begin
      op = $urandom_range(1) ? bdqs_pkg::OP_PUSH_BACK : bdqs_pkg::OP_PUSH_FRONT;
      add_item(op, pick_value(), i == 0, i == 4, 0);
    end
    count = DEPTH + 6;

    // segments biased toward growing, shrinking, or a balanced mix
    while (count < RANDOM_ITEMS) begin
      mode = $urandom_range(2);
      seg_len = $urandom_range(30, 100);
      seg_calm = ($urandom_range(3) == 0);
      seg_drain = ($urandom_range(3) == 0);
      push_pct = (mode == 0) ? 70 : (mode == 1) ? 15 : 40;
      for (int j = 0; j < seg_len && count < RANDOM_ITEMS; j++) begin
        r = $urandom_range(99);
        if (r < 2) begin
          op = bdqs_pkg::OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        end else if (r < 2 + push_pct) begin
          op = $urandom_range(1) ? bdqs_pkg::OP_PUSH_BACK : bdqs_pkg::OP_PUSH_FRONT;
        end else if (r < 22 + push_pct) begin
          op = bdqs_pkg::OP_SEARCH;
        end else begin
          op = $urandom_range(1) ? bdqs_pkg::OP_POP_BACK : bdqs_pkg::OP_POP_FRONT;
        end
        add_item(op, pick_value(), seg_drain && j == 0, 0, seg_calm);
        count++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
